/* rtl/core/ico_pkg.sv */
// Shared types and constants for the ICO file encoder.
// Used by the byte reader, the top level, the checker and the testbench.
package ico_pkg;

	localparam int SIDE_W = 9;
	localparam int AREA_W = 17;
	localparam int BSZ_W  = 19;
	localparam int OFS_W  = 24;
	localparam int COL_W  = 11;
	localparam int PIX_W  = 32;

	localparam int HDR_BYTES     = 6;
	localparam int DIR_BYTES     = 16;
	localparam int BMP_HDR_BYTES = 40;
	localparam int BITS_PER_PIX  = 32;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_BEGIN = 2'd1,
		OP_PIXEL = 2'd2,
		OP_READ  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_SIZE  = 2'd1,
		ST_NO_ROOM   = 2'd2,
		ST_NOT_READY = 2'd3
	} status_t;

	typedef enum logic [5:0] {
		PH_HEADER = 6'b000001,
		PH_DIR    = 6'b000010,
		PH_BMPHDR = 6'b000100,
		PH_COLOR  = 6'b001000,
		PH_MASK   = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	typedef enum logic [3:0] {
		RS_IDLE      = 4'b0001,
		RS_COLOR     = 4'b0010,
		RS_MASK      = 4'b0100,
		RS_MASK_LAST = 4'b1000
	} rd_state_t;

	typedef struct packed {
		logic [SIDE_W-1:0] w;
		logic [SIDE_W-1:0] h;
		logic [AREA_W-1:0] area;
		logic [BSZ_W-1:0]  bsize;
	} img_ent_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		status_t    status;
	} result_t;

	function automatic logic [7:0] le_byte(input logic [31:0] v, input logic [1:0] k);
		logic [7:0] b;
		case (k)
			2'd0:    b = v[7:0];
			2'd1:    b = v[15:8];
			2'd2:    b = v[23:16];
			default: b = v[31:24];
		endcase
		return b;
	endfunction

endpackage

/* rtl/core/ico_if.sv */
// Valid/ready channel interfaces for the ICO file encoder.
// Depends on nothing; the payload widths follow the item and result fields.
interface ico_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [8:0] width;
	logic [8:0] height;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	modport source (output valid, opcode, width, height, red, green, blue, alpha,
		input ready);
	modport sink (input valid, opcode, width, height, red, green, blue, alpha,
		output ready);
endinterface

interface ico_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic [1:0] status;
	modport source (output valid, data_byte, last_byte, status, input ready);
	modport sink (input valid, data_byte, last_byte, status, output ready);
endinterface

/* rtl/core/ico_ram.sv */
// Generic synchronous RAM: one write port, one read port, registered read.
// No dependencies.
module ico_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/core/ico_rd.sv */
// Read sequencer: walks the ICO file layout and produces one byte per request.
// Depends on ico_pkg; reads pixels through the read port of the top level's pixel RAM.
module ico_rd #(
	parameter int CW = 4,
	parameter int AW = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rewind,
	input  logic              start,
	input  logic [CW-1:0]     count,
	input  ico_pkg::img_ent_t ent,
	input  logic [AW-1:0]     base,
	input  logic [31:0]       rdata,
	output logic              re,
	output logic [AW-1:0]     raddr,
	output logic [CW-1:0]     img,
	output logic              at_end,
	output logic              busy,
	output logic              done,
	output ico_pkg::result_t  res
);
	ico_pkg::phase_t    phase_q;
	ico_pkg::rd_state_t rs_q;
	logic [ico_pkg::COL_W-1:0]  col_q;
	logic [ico_pkg::SIDE_W-1:0] row_q;
	logic [CW-1:0]              img_q;
	logic [AW-1:0]              row_addr_q;
	logic [ico_pkg::OFS_W-1:0]  offset_q;
	logic [2:0]                 k_q;
	logic [2:0]                 k_s1;
	logic                       v_s1;
	logic [7:0]                 acc_q;

	logic [7:0]  hdr_byte, dir_byte, bmp_byte, color_byte, mask_bit, byte_c;
	logic [31:0] bmp_word;
	logic [5:0]  mrb;
	logic [13:0] x0;
	logic [AW-1:0] first_row;
	logic        col_end, row_end, img_end, last_c;

	assign img    = img_q;
	assign at_end = (phase_q == ico_pkg::PH_DONE);
	assign busy   = (rs_q != ico_pkg::RS_IDLE);

	assign mrb       = {5'(({1'b0, ent.w} + 10'd31) >> 5), 1'b0} << 1;
	assign x0        = {3'b000, col_q} << 3;
	assign first_row = base + AW'(ent.area) - AW'(ent.w);
	assign img_end   = ({1'b0, img_q} + 1'b1) >= {1'b0, count};
	assign row_end   = ({1'b0, row_q} + 1'b1) >= {1'b0, ent.h};

	always_comb begin
		hdr_byte = 8'd0;
		if (col_q == 11'd2) begin
			hdr_byte = 8'd1;
		end else if (col_q == 11'd4) begin
			hdr_byte = 8'(count);
		end
		case (col_q[3:0])
			4'd0:    dir_byte = ent.w[7:0];
			4'd1:    dir_byte = ent.h[7:0];
			4'd4:    dir_byte = 8'd1;
			4'd6:    dir_byte = 8'(ico_pkg::BITS_PER_PIX);
			4'd8, 4'd9, 4'd10, 4'd11:
				dir_byte = ico_pkg::le_byte(32'(ent.bsize), col_q[1:0]);
			4'd12, 4'd13, 4'd14, 4'd15:
				dir_byte = ico_pkg::le_byte(32'(offset_q), col_q[1:0]);
			default: dir_byte = 8'd0;
		endcase
		case (col_q[5:2])
			4'd0:    bmp_word = 32'(ico_pkg::BMP_HDR_BYTES);
			4'd1:    bmp_word = 32'(ent.w);
			4'd2:    bmp_word = 32'({ent.h, 1'b0});
			4'd3:    bmp_word = 32'(ico_pkg::BITS_PER_PIX) << 16 | 32'd1;
			4'd5:    bmp_word = 32'({ent.area, 2'b00});
			default: bmp_word = 32'd0;
		endcase
		bmp_byte = ico_pkg::le_byte(bmp_word, col_q[1:0]);
		// Pixel words hold red in the low byte; the file wants B, G, R, A.
		case (col_q[1:0])
			2'd0:    color_byte = rdata[23:16];
			2'd1:    color_byte = rdata[15:8];
			2'd2:    color_byte = rdata[7:0];
			default: color_byte = rdata[31:24];
		endcase
		mask_bit = (v_s1 && rdata[31:24] == 8'd0) ? (8'h80 >> k_s1) : 8'd0;
	end

	// Request issue and completion.
	always_comb begin
		re      = 1'b0;
		raddr   = row_addr_q + AW'(x0) + AW'(k_q);
		done    = 1'b0;
		byte_c  = 8'd0;
		case (rs_q)
			ico_pkg::RS_IDLE: begin
				if (start) begin
					case (phase_q)
						ico_pkg::PH_HEADER: begin
							done = 1'b1; byte_c = hdr_byte;
						end
						ico_pkg::PH_DIR: begin
							done = 1'b1; byte_c = dir_byte;
						end
						ico_pkg::PH_BMPHDR: begin
							done = 1'b1; byte_c = bmp_byte;
						end
						ico_pkg::PH_COLOR: begin
							re    = 1'b1;
							raddr = row_addr_q + AW'(col_q[10:2]);
						end
						ico_pkg::PH_MASK: begin
							if (x0 >= 14'(ent.w)) begin
								done = 1'b1;
							end else begin
								re    = 1'b1;
								raddr = row_addr_q + AW'(x0);
							end
						end
						default: ;
					endcase
				end
			end
			ico_pkg::RS_COLOR: begin
				done   = 1'b1;
				byte_c = color_byte;
			end
			ico_pkg::RS_MASK: begin
				re = 1'b1;
			end
			ico_pkg::RS_MASK_LAST: begin
				done   = 1'b1;
				byte_c = acc_q | mask_bit;
			end
			default: ;
		endcase
	end

	always_comb begin
		case (phase_q)
			ico_pkg::PH_COLOR: col_end = (12'(col_q) + 12'd1) >= 12'({ent.w, 2'b00});
			ico_pkg::PH_MASK:  col_end = (12'(col_q) + 12'd1) >= 12'(mrb);
			default:           col_end = 1'b0;
		endcase
		last_c = (phase_q == ico_pkg::PH_MASK) && col_end && row_end && img_end;
	end

	assign res.data_byte = byte_c;
	assign res.last_byte = done && last_c;
	assign res.status    = ico_pkg::ST_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q <= ico_pkg::RS_IDLE;
			v_s1 <= 1'b0;
			k_q  <= 3'd0;
		end else begin
			case (rs_q)
				ico_pkg::RS_IDLE: begin
					v_s1 <= 1'b0;
					if (start && phase_q == ico_pkg::PH_COLOR) begin
						rs_q <= ico_pkg::RS_COLOR;
					end else if (start && phase_q == ico_pkg::PH_MASK && !done) begin
						v_s1 <= 1'b1;
						k_q  <= 3'd1;
						if (x0 + 14'd1 >= 14'(ent.w)) begin
							rs_q <= ico_pkg::RS_MASK_LAST;
						end else begin
							rs_q <= ico_pkg::RS_MASK;
						end
					end
				end
				ico_pkg::RS_COLOR: rs_q <= ico_pkg::RS_IDLE;
				ico_pkg::RS_MASK: begin
					v_s1 <= 1'b1;
					k_q  <= k_q + 3'd1;
					if (k_q == 3'd7 || x0 + 14'(k_q) + 14'd1 >= 14'(ent.w)) begin
						rs_q <= ico_pkg::RS_MASK_LAST;
					end
				end
				ico_pkg::RS_MASK_LAST: begin
					v_s1 <= 1'b0;
					rs_q <= ico_pkg::RS_IDLE;
				end
				default: rs_q <= ico_pkg::RS_IDLE;
			endcase
		end
	end

	// Mask byte accumulator and the bit index that goes with each RAM read.
	always_ff @(posedge clk) begin
		k_s1 <= (rs_q == ico_pkg::RS_IDLE) ? 3'd0 : k_q;
		if (rs_q == ico_pkg::RS_IDLE) begin
			acc_q <= 8'd0;
		end else begin
			acc_q <= acc_q | mask_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ico_pkg::PH_HEADER;
			col_q      <= '0;
			row_q      <= '0;
			img_q      <= '0;
			offset_q   <= '0;
			row_addr_q <= '0;
		end else if (rewind) begin
			phase_q  <= ico_pkg::PH_HEADER;
			col_q    <= '0;
			row_q    <= '0;
			img_q    <= '0;
			offset_q <= '0;
		end else if (done) begin
			case (phase_q)
				ico_pkg::PH_HEADER: begin
					if (col_q == 11'(ico_pkg::HDR_BYTES - 1)) begin
						phase_q  <= ico_pkg::PH_DIR;
						col_q    <= '0;
						img_q    <= '0;
						offset_q <= ico_pkg::OFS_W'(ico_pkg::HDR_BYTES)
							+ ico_pkg::OFS_W'({count, 4'b0000});
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ico_pkg::PH_DIR: begin
					if (col_q == 11'(ico_pkg::DIR_BYTES - 1)) begin
						col_q    <= '0;
						offset_q <= offset_q + ico_pkg::OFS_W'(ent.bsize);
						if (img_end) begin
							img_q   <= '0;
							phase_q <= ico_pkg::PH_BMPHDR;
						end else begin
							img_q <= img_q + 1'b1;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ico_pkg::PH_BMPHDR: begin
					if (col_q == 11'(ico_pkg::BMP_HDR_BYTES - 1)) begin
						col_q      <= '0;
						row_q      <= '0;
						phase_q    <= ico_pkg::PH_COLOR;
						row_addr_q <= first_row;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ico_pkg::PH_COLOR: begin
					if (col_end) begin
						col_q <= '0;
						if (row_end) begin
							row_q      <= '0;
							phase_q    <= ico_pkg::PH_MASK;
							row_addr_q <= first_row;
						end else begin
							row_q      <= row_q + 1'b1;
							row_addr_q <= row_addr_q - AW'(ent.w);
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ico_pkg::PH_MASK: begin
					if (col_end) begin
						col_q <= '0;
						if (row_end) begin
							row_q <= '0;
							if (img_end) begin
								phase_q <= ico_pkg::PH_DONE;
							end else begin
								img_q   <= img_q + 1'b1;
								phase_q <= ico_pkg::PH_BMPHDR;
							end
						end else begin
							row_q      <= row_q + 1'b1;
							row_addr_q <= row_addr_q - AW'(ent.w);
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

/* rtl/core/ico_file_encoder_core.sv */
// ICO file encoder, 32 bits per pixel: top level.
// Channels on the item and result interfaces; images enter through requests on
// the item channel (clear, begin image, pixel, read byte) and every request
// yields exactly one result on the result channel.
// Pixels are stored in one synchronous RAM of PIXEL_STORE words; per-image
// sizes, bases and bitmap byte counts sit in small register tables.
// Clear, begin, pixel and reads of header, directory and bitmap-header bytes
// finish in the cycle they are accepted, and the result is registered; a color
// byte waits for one RAM read; a mask byte issues one RAM read per pixel that
// it covers (at most 8) and finishes after the last of them; a padding mask
// byte finishes in the cycle it is accepted.
// A new request is taken when the reader is idle and the result register is
// empty or being drained.
// Reset clears all counters and returns the read pointer to the file start;
// the pixel RAM keeps no reset value and needs no clearing pass.
// When the receiver stalls, the result register holds and no new request is
// taken until it has been drained.
module ico_file_encoder_core #(
	parameter int MAX_IMAGES  = 8,
	parameter int PIXEL_STORE = 131072,
	parameter int MAX_SIDE    = 256
) (
	input  logic  clk,
	input  logic  arst_n,
	ico_item_if.sink     item,
	ico_result_if.source result
);
	localparam int AW = $clog2(PIXEL_STORE);
	localparam int CW = $clog2(MAX_IMAGES + 1);
	localparam int IW = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;

	ico_pkg::img_ent_t ent_q [MAX_IMAGES];
	logic [AW-1:0]     base_q [MAX_IMAGES];

	logic [CW-1:0]              count_q;
	logic [ico_pkg::AREA_W-1:0] loaded_q;
	logic [ico_pkg::AREA_W-1:0] last_area_q;
	logic [AW-1:0]              last_base_q;
	logic [AW:0]                total_q;

	logic              out_valid_q;
	ico_pkg::result_t  out_q;

	logic              acc, complete, bad, no_room, rd_start, rewind, out_load;
	logic              begin_ok, pixel_ok;
	logic [17:0]       area;
	logic [5:0]        mrb;
	logic [ico_pkg::BSZ_W-1:0] bsize;
	ico_pkg::status_t  imm_status;
	ico_pkg::result_t  rd_res;
	logic              rd_done, rd_busy, rd_at_end, ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [CW-1:0]     rd_img;
	logic [31:0]       ram_rdata;

	assign item.ready = !rd_busy && (!out_valid_q || result.ready);
	assign acc        = item.valid && item.ready;
	assign complete   = (count_q == '0) || (loaded_q >= last_area_q);

	assign area  = item.width * item.height;
	assign mrb   = {5'(({1'b0, item.width} + 10'd31) >> 5), 1'b0} << 1;
	assign bsize = ico_pkg::BSZ_W'(ico_pkg::BMP_HDR_BYTES) + ico_pkg::BSZ_W'({area, 2'b00})
		+ ico_pkg::BSZ_W'(mrb) * ico_pkg::BSZ_W'(item.height);
	assign bad = (item.width == '0) || (item.height == '0)
		|| (item.width > ico_pkg::SIDE_W'(MAX_SIDE))
		|| (item.height > ico_pkg::SIDE_W'(MAX_SIDE));
	assign no_room = (count_q >= CW'(MAX_IMAGES))
		|| ((AW + 2)'(total_q) + (AW + 2)'(area) > (AW + 2)'(PIXEL_STORE));

	always_comb begin
		imm_status = ico_pkg::ST_OK;
		begin_ok   = 1'b0;
		pixel_ok   = 1'b0;
		rd_start   = 1'b0;
		case (ico_pkg::opcode_t'(item.opcode))
			ico_pkg::OP_CLEAR: ;
			ico_pkg::OP_BEGIN: begin
				if (bad) begin
					imm_status = ico_pkg::ST_BAD_SIZE;
				end else if (!complete) begin
					imm_status = ico_pkg::ST_NOT_READY;
				end else if (no_room) begin
					imm_status = ico_pkg::ST_NO_ROOM;
				end else begin
					begin_ok = acc;
				end
			end
			ico_pkg::OP_PIXEL: begin
				if (complete) begin
					imm_status = ico_pkg::ST_NO_ROOM;
				end else begin
					pixel_ok = acc;
				end
			end
			ico_pkg::OP_READ: begin
				if (count_q == '0 || !complete || rd_at_end) begin
					imm_status = ico_pkg::ST_NOT_READY;
				end else begin
					rd_start = acc;
				end
			end
			default: ;
		endcase
	end

	assign rewind = begin_ok || pixel_ok
		|| (acc && ico_pkg::opcode_t'(item.opcode) == ico_pkg::OP_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			loaded_q    <= '0;
			last_area_q <= '0;
			last_base_q <= '0;
			total_q     <= '0;
		end else if (acc && ico_pkg::opcode_t'(item.opcode) == ico_pkg::OP_CLEAR) begin
			count_q  <= '0;
			loaded_q <= '0;
			total_q  <= '0;
		end else if (begin_ok) begin
			count_q     <= count_q + 1'b1;
			loaded_q    <= '0;
			last_area_q <= ico_pkg::AREA_W'(area);
			last_base_q <= total_q[AW-1:0];
			total_q     <= total_q + (AW + 1)'(area);
		end else if (pixel_ok) begin
			loaded_q <= loaded_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (begin_ok) begin
			ent_q[count_q[IW-1:0]]  <= '{w: item.width, h: item.height,
				area: ico_pkg::AREA_W'(area), bsize: bsize};
			base_q[count_q[IW-1:0]] <= total_q[AW-1:0];
		end
	end

	ico_ram #(
		.WIDTH(ico_pkg::PIX_W),
		.DEPTH(PIXEL_STORE)
	) u_pix_ram (
		.clk   (clk),
		.we    (pixel_ok),
		.waddr (last_base_q + AW'(loaded_q)),
		.wdata ({item.alpha, item.blue, item.green, item.red}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ico_rd #(
		.CW(CW),
		.AW(AW)
	) u_rd (
		.clk    (clk),
		.arst_n (arst_n),
		.rewind (rewind),
		.start  (rd_start),
		.count  (count_q),
		.ent    (ent_q[rd_img[IW-1:0]]),
		.base   (base_q[rd_img[IW-1:0]]),
		.rdata  (ram_rdata),
		.re     (ram_re),
		.raddr  (ram_raddr),
		.img    (rd_img),
		.at_end (rd_at_end),
		.busy   (rd_busy),
		.done   (rd_done),
		.res    (rd_res)
	);

	assign out_load = (acc && !rd_start) || rd_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (rd_done) begin
				out_q <= rd_res;
			end else begin
				out_q <= '{data_byte: 8'd0, last_byte: 1'b0, status: imm_status};
			end
		end
	end

	assign result.valid     = out_valid_q;
	assign result.data_byte = out_q.data_byte;
	assign result.last_byte = out_q.last_byte;
	assign result.status    = out_q.status;
endmodule

/* rtl/core/ico_chk.sv */
// Port-level checker for the ICO file encoder, bound to the top level.
// Depends on ico_pkg for the status codes.
module ico_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] data_byte,
	input logic       last_byte,
	input logic [1:0] status
);
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && last_byte |-> status == ico_pkg::ST_OK)
		else $error("final byte flagged on a failed request");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != ico_pkg::ST_OK |-> data_byte == 8'd0)
		else $error("failed request carries data");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> res_valid || !item_ready)
		else $error("request accepted with no result pending or in work");
endmodule

bind ico_file_encoder_core ico_chk u_ico_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.data_byte  (result.data_byte),
	.last_byte  (result.last_byte),
	.status     (result.status)
);

/* tb/sv/ico_scoreboard.sv */
`timescale 1ns / 1ps
// Watches both channels of the ICO file encoder, predicts every result and compares.
// Depends on ico_pkg and the channel interfaces in ico_if.sv.
module ico_scoreboard #(
	parameter int MAX_IMAGES  = 8,
	parameter int PIXEL_STORE = 131072,
	parameter int MAX_SIDE    = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	ico_item_if     item,
	ico_result_if   result,
	output int      errors,
	output int      pending,
	output int      results_seen
);
	typedef struct {
		logic [7:0]       data_byte;
		logic             last_byte;
		ico_pkg::status_t status;
	} byte_result_t;

	logic [31:0] pix_mem [PIXEL_STORE];
	bit          clear_mem [PIXEL_STORE];
	int unsigned img_w [MAX_IMAGES];
	int unsigned img_h [MAX_IMAGES];
	int unsigned n_img, n_loaded, cur_img, cur_row, cur_col, file_ofs;
	ico_pkg::phase_t ph;
	byte_result_t expected_results [$];

	function automatic int unsigned base_of(int unsigned n);
		int unsigned s;
		s = 0;
		for (int unsigned i = 0; i < n && i < MAX_IMAGES; i++)
			s += img_w[i] * img_h[i];
		return s;
	endfunction

	function automatic int unsigned mask_bytes(int unsigned w);
		return ((w + 31) / 32) * 4;
	endfunction

	function automatic int unsigned bmp_size(int unsigned i);
		return 40 + 4 * img_w[i] * img_h[i] + mask_bytes(img_w[i]) * img_h[i];
	endfunction

	function automatic logic [7:0] pick(int unsigned v, int unsigned k);
		return 8'(v >> (8 * (k % 4)));
	endfunction

	function automatic bit image_done();
		if (n_img == 0)
			return 1'b1;
		return n_loaded >= img_w[n_img-1] * img_h[n_img-1];
	endfunction

	function automatic void rewind();
		ph = ico_pkg::PH_HEADER;
		cur_img = 0;
		cur_row = 0;
		cur_col = 0;
		file_ofs = 0;
	endfunction

	// Produces the next file byte and advances the read pointer.
	function automatic logic [7:0] next_file_byte(output logic last);
		int unsigned w, h, c, v, y, base, idx;
		logic [31:0] p;
		logic [7:0] b;
		b = 8'd0;
		last = 1'b0;
		w = img_w[cur_img];
		h = img_h[cur_img];
		c = cur_col;
		case (ph)
			ico_pkg::PH_HEADER: begin
				b = (c == 2) ? 8'd1 : (c == 4) ? 8'(n_img) : 8'd0;
				if (++cur_col >= 6) begin
					ph = ico_pkg::PH_DIR;
					cur_col = 0;
					cur_img = 0;
					file_ofs = 6 + 16 * n_img;
				end
			end
			ico_pkg::PH_DIR: begin
				if (c == 0) b = 8'(w % 256);
				else if (c == 1) b = 8'(h % 256);
				else if (c == 4) b = 8'd1;
				else if (c == 6) b = 8'd32;
				else if (c >= 8 && c < 12) b = pick(bmp_size(cur_img), c);
				else if (c >= 12) b = pick(file_ofs, c);
				if (++cur_col >= 16) begin
					cur_col = 0;
					file_ofs += bmp_size(cur_img);
					if (++cur_img >= n_img) begin
						cur_img = 0;
						ph = ico_pkg::PH_BMPHDR;
					end
				end
			end
			ico_pkg::PH_BMPHDR: begin
				case (c / 4)
					0: v = 40;
					1: v = w;
					2: v = 2 * h;
					3: v = 1 | (32 << 16);
					5: v = 4 * w * h;
					default: v = 0;
				endcase
				b = pick(v, c);
				if (++cur_col >= 40) begin
					cur_col = 0;
					cur_row = 0;
					ph = ico_pkg::PH_COLOR;
				end
			end
			ico_pkg::PH_COLOR: begin
				y = h - 1 - cur_row;
				idx = base_of(cur_img) + y * w + c / 4;
				p = pix_mem[idx];
				case (c % 4)
					0: b = p[23:16];
					1: b = p[15:8];
					2: b = p[7:0];
					default: b = p[31:24];
				endcase
				if (++cur_col >= 4 * w) begin
					cur_col = 0;
					if (++cur_row >= h) begin
						cur_row = 0;
						ph = ico_pkg::PH_MASK;
					end
				end
			end
			ico_pkg::PH_MASK: begin
				y = h - 1 - cur_row;
				base = base_of(cur_img) + y * w;
				for (int unsigned k = 0; k < 8; k++)
					if (c * 8 + k < w && clear_mem[base + c * 8 + k])
						b[7-k] = 1'b1;
				if (++cur_col >= mask_bytes(w)) begin
					cur_col = 0;
					if (++cur_row >= h) begin
						cur_row = 0;
						if (++cur_img >= n_img) begin
							ph = ico_pkg::PH_DONE;
							last = 1'b1;
						end else begin
							ph = ico_pkg::PH_BMPHDR;
						end
					end
				end
			end
			default: ;
		endcase
		return b;
	endfunction

	function automatic byte_result_t encode_request(ico_pkg::opcode_t op, int unsigned w,
			int unsigned h, logic [31:0] rgba);
		byte_result_t r;
		int unsigned idx;
		r.data_byte = 8'd0;
		r.last_byte = 1'b0;
		r.status = ico_pkg::ST_OK;
		case (op)
			ico_pkg::OP_CLEAR: begin
				n_img = 0;
				n_loaded = 0;
				rewind();
			end
			ico_pkg::OP_BEGIN: begin
				if (w == 0 || h == 0 || w > MAX_SIDE || h > MAX_SIDE)
					r.status = ico_pkg::ST_BAD_SIZE;
				else if (!image_done())
					r.status = ico_pkg::ST_NOT_READY;
				else if (n_img >= MAX_IMAGES || base_of(n_img) + w * h > PIXEL_STORE)
					r.status = ico_pkg::ST_NO_ROOM;
				else begin
					img_w[n_img] = w;
					img_h[n_img] = h;
					n_img++;
					n_loaded = 0;
					rewind();
				end
			end
			ico_pkg::OP_PIXEL: begin
				if (n_img == 0 || image_done())
					r.status = ico_pkg::ST_NO_ROOM;
				else begin
					idx = base_of(n_img - 1) + n_loaded;
					pix_mem[idx] = rgba;
					clear_mem[idx] = (rgba[31:24] == 8'd0);
					n_loaded++;
					rewind();
				end
			end
			default: begin
				if (n_img == 0 || !image_done() || ph == ico_pkg::PH_DONE)
					r.status = ico_pkg::ST_NOT_READY;
				else
					r.data_byte = next_file_byte(r.last_byte);
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		byte_result_t e;
		int n_bad;
		if (!arst_n) begin
			n_img = 0;
			n_loaded = 0;
			rewind();
			expected_results.delete();
			errors <= 0;
			results_seen <= 0;
			pending <= 0;
		end else begin
			n_bad = 0;
			if (result.valid && result.ready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					$error("unexpected result: data_byte %0h last_byte %0b status %0d",
						result.data_byte, result.last_byte, result.status);
					n_bad++;
				end else begin
					e = expected_results.pop_front();
					if (result.data_byte !== e.data_byte) begin
						$error("data_byte: expected %0h, got %0h", e.data_byte, result.data_byte);
						n_bad++;
					end
					if (result.last_byte !== e.last_byte) begin
						$error("last_byte: expected %0b, got %0b", e.last_byte, result.last_byte);
						n_bad++;
					end
					if (result.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, result.status);
						n_bad++;
					end
				end
			end
			if (item.valid && item.ready)
				expected_results.insert(expected_results.size(),
					encode_request(ico_pkg::opcode_t'(item.opcode),
					item.width, item.height,
					{item.alpha, item.blue, item.green, item.red}));
			if (n_bad != 0)
				errors <= errors + n_bad;
			pending <= expected_results.size();
		end
	end
endmodule

/* tb/sv/tb_ico_file_encoder_core.sv */
`timescale 1ns / 1ps
// Top of the ICO file encoder testbench: clock, reset, request stimulus and verdict.
// Depends on ico_pkg, ico_if.sv, the encoder core and ico_scoreboard.
module tb_ico_file_encoder_core;
	logic clk;
	logic arst_n;
	int   errors, pending, results_seen;
	int   requests, images_begun, bytes_read;
	bit   quiet;
	int   ready_hold;

	ico_item_if   item ();
	ico_result_if result ();

	ico_file_encoder_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source)
	);

	ico_scoreboard checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result       (result),
		.errors       (errors),
		.pending      (pending),
		.results_seen (results_seen)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver side: stalls in random bursts until the quiet tail.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			ready_hold <= 0;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			result.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			ready_hold <= $urandom_range(0, 12);
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
		end
	end

	task automatic send(ico_pkg::opcode_t op, logic [8:0] w = 9'd0, logic [8:0] h = 9'd0,
			logic [31:0] rgba = 32'd0);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		item.valid  <= 1'b1;
		item.opcode <= op;
		item.width  <= w;
		item.height <= h;
		item.red    <= rgba[7:0];
		item.green  <= rgba[15:8];
		item.blue   <= rgba[23:16];
		item.alpha  <= rgba[31:24];
		do @(posedge clk); while (!item.ready);
		requests++;
		if (op == ico_pkg::OP_READ)
			bytes_read++;
	endtask

	function automatic logic [31:0] rand_pixel();
		logic [31:0] p;
		p = $urandom;
		if ($urandom_range(0, 2) == 0)
			p[31:24] = 8'd0;
		return p;
	endfunction

	// Loads one image completely and adds its share to the file length.
	task automatic load_image(int w, int h, inout int file_len);
		send(ico_pkg::OP_BEGIN, 9'(w), 9'(h));
		images_begun++;
		for (int i = 0; i < w * h; i++)
			send(ico_pkg::OP_PIXEL, 9'd0, 9'd0, rand_pixel());
		file_len += 16 + 40 + 4 * w * h + ((w + 31) / 32) * 4 * h;
	endtask

	task automatic read_bytes(int n_bytes);
		repeat (n_bytes)
			send(ico_pkg::OP_READ);
	endtask

	task automatic read_file(int file_len);
		read_bytes(file_len + $urandom_range(0, 2));
	endtask

	initial begin
		int len, n, w, h;
		quiet = 0;
		requests = 0;
		images_begun = 0;
		bytes_read = 0;
		item.valid = 0;
		item.opcode = ico_pkg::OP_CLEAR;
		item.width = 0;
		item.height = 0;
		item.red = 0;
		item.green = 0;
		item.blue = 0;
		item.alpha = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;

		// Directed: error cases, then a 2x1 image with extreme pixel values, with more error requests while it loads.
		send(ico_pkg::OP_READ);
		send(ico_pkg::OP_PIXEL, 9'd0, 9'd0, 32'hFFFF_FFFF);
		send(ico_pkg::OP_BEGIN, 9'd0, 9'd5);
		send(ico_pkg::OP_BEGIN, 9'd5, 9'd0);
		send(ico_pkg::OP_BEGIN, 9'd257, 9'd1);
		send(ico_pkg::OP_BEGIN, 9'h1FF, 9'h1FF);
		send(ico_pkg::OP_BEGIN, 9'd2, 9'd1);
		send(ico_pkg::OP_READ);
		send(ico_pkg::OP_BEGIN, 9'd1, 9'd1);
		send(ico_pkg::OP_PIXEL, 9'd0, 9'd0, 32'h00FF_FFFF);
		send(ico_pkg::OP_PIXEL, 9'd0, 9'd0, 32'hFF00_0000);
		send(ico_pkg::OP_PIXEL, 9'd0, 9'd0, 32'h1234_5678);
		images_begun++;
		read_file(6 + 16 + 40 + 8 + 4);
		send(ico_pkg::OP_CLEAR);

		// Largest sides, one long dimension each; the start of each file is read.
		len = 6;
		load_image(256, 1, len);
		read_bytes(30);
		send(ico_pkg::OP_CLEAR);
		len = 6;
		load_image(1, 256, len);
		read_bytes(30);

		// Fill every image slot, then ask for one more.
		send(ico_pkg::OP_CLEAR);
		len = 6;
		for (int i = 0; i < 8; i++)
			load_image(1, 1, len);
		send(ico_pkg::OP_BEGIN, 9'd1, 9'd1);
		read_bytes(22);

		// Random: mostly well-formed files, some noise.
		while (requests < 740) begin
			if ($urandom_range(0, 3) != 0) begin
				send(ico_pkg::OP_CLEAR);
				len = 6;
				n = $urandom_range(1, 2);
				for (int i = 0; i < n; i++) begin
					w = $urandom_range(1, 40);
					h = $urandom_range(1, 2);
					if (w * h > 24)
						h = 1;
					load_image(w, h, len);
				end
				read_file(len);
			end else begin
				repeat ($urandom_range(1, 10))
					send(ico_pkg::opcode_t'($urandom_range(0, 3)), 9'($urandom),
						9'($urandom), $urandom);
			end
		end

		// Tail with no idling on either side: one complete file back to back.
		quiet = 1;
		send(ico_pkg::OP_CLEAR);
		len = 6;
		load_image(3, 2, len);
		read_file(len);

		item.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		$display("Covered %0d requests and %0d results: %0d images begun, %0d byte reads.",
			requests, results_seen, images_begun, bytes_read);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
